@@ src/spsn_pkg.sv @@
// ----------------------------------------------------------------------------
// spsn_pkg
// Shared types, codes and saturating fixed point helpers for the path
// segment normalizer.
// ----------------------------------------------------------------------------
package spsn_pkg;

   // internal coordinate width (Q16.16 at 32)
   localparam int COORD_BITS = 32;
   // external field width of every coordinate
   localparam int FIELD_BITS = 32;
   // working width: holds any field or coordinate plus two bits of growth
   localparam int EXT_BITS = ((COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS) + 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [EXT_BITS-1:0]   ext_type;
   typedef logic signed [FIELD_BITS-1:0] field_type;

   // path command codes
   typedef enum logic [3:0] {
      CMD_MOVE         = 4'd0,
      CMD_LINE         = 4'd1,
      CMD_HORIZONTAL   = 4'd2,
      CMD_VERTICAL     = 4'd3,
      CMD_CLOSE        = 4'd4,
      CMD_QUAD         = 4'd5,
      CMD_SMOOTH_QUAD  = 4'd6,
      CMD_CUBIC        = 4'd7,
      CMD_SMOOTH_CUBIC = 4'd8
   } command_type;

   // segment kind; as a curve history, line means no previous curve
   typedef enum logic [1:0] {
      KIND_LINE  = 2'd0,
      KIND_QUAD  = 2'd1,
      KIND_CUBIC = 2'd2
   } kind_type;

   typedef struct packed {
      logic [3:0] command;
      logic       relative;
      field_type  coord_a;
      field_type  coord_b;
      field_type  coord_c;
      field_type  coord_d;
      field_type  coord_e;
      field_type  coord_f;
   } req_type;

   typedef struct packed {
      logic [1:0] segment_kind;
      field_type  start_x;
      field_type  start_y;
      field_type  first_ctrl_x;
      field_type  first_ctrl_y;
      field_type  second_ctrl_x;
      field_type  second_ctrl_y;
      field_type  end_x;
      field_type  end_y;
   } rsp_type;

   // tracked path state
   typedef struct packed {
      coord_type origin_x;
      coord_type origin_y;
      coord_type current_x;
      coord_type current_y;
      coord_type prev_ctrl_x;
      coord_type prev_ctrl_y;
      kind_type  prev_curve_kind;
   } state_type;

   localparam ext_type COORD_MAX = {{(EXT_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam ext_type COORD_MIN = ~COORD_MAX;

   // clamp a working value into the coordinate range
   function automatic coord_type sat(input ext_type v);
      ext_type r;
      r = v;
      if (v > COORD_MAX) r = COORD_MAX;
      if (v < COORD_MIN) r = COORD_MIN;
      return r[COORD_BITS-1:0];
   endfunction

   function automatic coord_type sat_add(input coord_type a, input coord_type b);
      return sat(EXT_BITS'(a) + EXT_BITS'(b));
   endfunction

   function automatic coord_type sat_sub(input coord_type a, input coord_type b);
      return sat(EXT_BITS'(a) - EXT_BITS'(b));
   endfunction

   // field to coordinate, clamped
   function automatic coord_type from_field(input field_type v);
      return sat(EXT_BITS'(v));
   endfunction

   // coordinate to field, low bits of the two's complement value
   function automatic field_type to_field(input coord_type v);
      ext_type e;
      e = EXT_BITS'(v);
      return e[FIELD_BITS-1:0];
   endfunction

endpackage

@@ src/svg_path_segment_normalizer_unit.sv @@
// ----------------------------------------------------------------------------
// svg_path_segment_normalizer_unit
// Turns parsed path commands into absolute line, quadratic and cubic
// segments, tracking subpath origin, current point and last control point.
// ----------------------------------------------------------------------------
//  channel  | direction | payload            | handshake
//  ---------+-----------+--------------------+----------------------
//  req_     | in        | spsn_pkg::req_type | req_valid / req_ready
//  rsp_     | out       | spsn_pkg::rsp_type | rsp_valid / rsp_ready
//
//  One transaction per cycle sustained while rsp_ready is high; a segment passes
//  through the command register, then the result register, before it is
//  presented on rsp_.
//  Move and unknown commands update state (or not) and give no segment.
//  Reset clears the path state to zero and empties both registers.
//  A stalled result holds the command register; commands without a segment
//  still drain while the result waits.
// ----------------------------------------------------------------------------
module svg_path_segment_normalizer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  spsn_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spsn_pkg::rsp_type rsp_data
);
   import spsn_pkg::*;

   logic      cmd_valid_ff, cmd_valid_in;
   req_type   cmd_data_ff, cmd_data_in;
   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_data_ff, out_data_in;

   state_type core_state;
   rsp_type   core_seg;
   logic      core_seg_valid;
   logic      advance;

   spsn_core u_core (
      .cmd_data   (cmd_data_ff),
      .state_cur  (state_ff),
      .state_next (core_state),
      .seg_data   (core_seg),
      .seg_valid  (core_seg_valid)
   );

   // command leaves the register when it gives no segment or its segment has somewhere to go
   assign advance   = cmd_valid_ff & (~core_seg_valid | ~out_valid_ff | rsp_ready);
   assign req_ready = ~cmd_valid_ff | advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // next values
   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      cmd_data_in  = cmd_data_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      if (advance) begin
         cmd_valid_in = 1'b0;
         state_in     = core_state;
         if (core_seg_valid) begin
            out_valid_in = 1'b1;
            out_data_in  = core_seg;
         end
      end
      if (req_valid && req_ready) begin
         cmd_valid_in = 1'b1;
         cmd_data_in  = req_data;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_data_ff <= cmd_data_in;
      out_data_ff <= out_data_in;
   end

endmodule

@@ src/spsn_core.sv @@
// ----------------------------------------------------------------------------
// spsn_core
// Combinational command decode: builds the absolute segment and the next
// path state from one command and the current state.
// ----------------------------------------------------------------------------
module spsn_core (
   input  spsn_pkg::req_type   cmd_data,
   input  spsn_pkg::state_type state_cur,
   output spsn_pkg::state_type state_next,
   output spsn_pkg::rsp_type   seg_data,
   output logic                seg_valid
);
   import spsn_pkg::*;

   coord_type a_x, a_y, c_x, c_y, e_x, e_y;
   coord_type rc_a_x, rc_a_y;
   coord_type vert_y;
   coord_type refl_x, refl_y;
   coord_type c1_x, c1_y, c2_x, c2_y, end_x, end_y;
   kind_type  kind;

   // operand points, offset by the current point when relative
   always_comb begin
      a_x = from_field(cmd_data.coord_a);
      a_y = from_field(cmd_data.coord_b);
      c_x = from_field(cmd_data.coord_c);
      c_y = from_field(cmd_data.coord_d);
      e_x = from_field(cmd_data.coord_e);
      e_y = from_field(cmd_data.coord_f);
      rc_a_x = a_x;
      rc_a_y = a_y;
      // vertical takes its y from the first operand
      vert_y = a_x;
      if (cmd_data.relative) begin
         rc_a_x = sat_add(a_x, state_cur.current_x);
         rc_a_y = sat_add(a_y, state_cur.current_y);
         vert_y = sat_add(a_x, state_cur.current_y);
         c_x    = sat_add(c_x, state_cur.current_x);
         c_y    = sat_add(c_y, state_cur.current_y);
         e_x    = sat_add(e_x, state_cur.current_x);
         e_y    = sat_add(e_y, state_cur.current_y);
      end
   end

   // reflection of the last control point about the current point
   always_comb begin
      refl_x = sat_add(state_cur.current_x,
                       sat_sub(state_cur.current_x, state_cur.prev_ctrl_x));
      refl_y = sat_add(state_cur.current_y,
                       sat_sub(state_cur.current_y, state_cur.prev_ctrl_y));
   end

   // command decode
   always_comb begin
      state_next = state_cur;
      seg_valid  = 1'b0;
      kind       = KIND_LINE;
      c1_x       = '0;
      c1_y       = '0;
      c2_x       = '0;
      c2_y       = '0;
      end_x      = state_cur.current_x;
      end_y      = state_cur.current_y;
      unique case (cmd_data.command)
         CMD_MOVE: begin
            state_next.origin_x        = rc_a_x;
            state_next.origin_y        = rc_a_y;
            state_next.current_x       = rc_a_x;
            state_next.current_y       = rc_a_y;
            state_next.prev_ctrl_x     = rc_a_x;
            state_next.prev_ctrl_y     = rc_a_y;
            state_next.prev_curve_kind = KIND_LINE;
         end
         CMD_LINE: begin
            seg_valid = 1'b1;
            end_x     = rc_a_x;
            end_y     = rc_a_y;
         end
         CMD_HORIZONTAL: begin
            seg_valid = 1'b1;
            end_x     = rc_a_x;
         end
         CMD_VERTICAL: begin
            seg_valid = 1'b1;
            end_y     = vert_y;
         end
         CMD_CLOSE: begin
            seg_valid = 1'b1;
            end_x     = state_cur.origin_x;
            end_y     = state_cur.origin_y;
         end
         CMD_QUAD: begin
            seg_valid = 1'b1;
            kind      = KIND_QUAD;
            c1_x      = rc_a_x;
            c1_y      = rc_a_y;
            end_x     = c_x;
            end_y     = c_y;
            state_next.prev_ctrl_x = rc_a_x;
            state_next.prev_ctrl_y = rc_a_y;
         end
         CMD_SMOOTH_QUAD: begin
            seg_valid = 1'b1;
            kind      = KIND_QUAD;
            c1_x      = state_cur.current_x;
            c1_y      = state_cur.current_y;
            if (state_cur.prev_curve_kind == KIND_QUAD) begin
               c1_x = refl_x;
               c1_y = refl_y;
            end
            end_x     = rc_a_x;
            end_y     = rc_a_y;
            state_next.prev_ctrl_x = c1_x;
            state_next.prev_ctrl_y = c1_y;
         end
         CMD_CUBIC: begin
            seg_valid = 1'b1;
            kind      = KIND_CUBIC;
            c1_x      = rc_a_x;
            c1_y      = rc_a_y;
            c2_x      = c_x;
            c2_y      = c_y;
            end_x     = e_x;
            end_y     = e_y;
            state_next.prev_ctrl_x = c_x;
            state_next.prev_ctrl_y = c_y;
         end
         CMD_SMOOTH_CUBIC: begin
            seg_valid = 1'b1;
            kind      = KIND_CUBIC;
            c1_x      = state_cur.current_x;
            c1_y      = state_cur.current_y;
            if (state_cur.prev_curve_kind == KIND_CUBIC) begin
               c1_x = refl_x;
               c1_y = refl_y;
            end
            c2_x      = rc_a_x;
            c2_y      = rc_a_y;
            end_x     = c_x;
            end_y     = c_y;
            state_next.prev_ctrl_x = rc_a_x;
            state_next.prev_ctrl_y = rc_a_y;
         end
         default: begin
            seg_valid = 1'b0;
         end
      endcase
      // a segment moves the current point and records its curve kind
      if (seg_valid) begin
         state_next.current_x       = end_x;
         state_next.current_y       = end_y;
         state_next.prev_curve_kind = kind;
      end
   end

   // segment fields
   always_comb begin
      seg_data.segment_kind  = kind;
      seg_data.start_x       = to_field(state_cur.current_x);
      seg_data.start_y       = to_field(state_cur.current_y);
      seg_data.first_ctrl_x  = to_field(c1_x);
      seg_data.first_ctrl_y  = to_field(c1_y);
      seg_data.second_ctrl_x = to_field(c2_x);
      seg_data.second_ctrl_y = to_field(c2_y);
      seg_data.end_x         = to_field(end_x);
      seg_data.end_y         = to_field(end_y);
   end

endmodule
